// ----- sv/pfe_pkg.sv -----
// Shared constants, codes and the queued operation type for the page frame store.
package pfe_pkg;

  // Frame geometry
  localparam int COLUMNS    = 128;
  localparam int ROWS       = 64;
  localparam int PAGES      = (ROWS + 7) / 8;
  localparam int STORE_SIZE = COLUMNS * PAGES;
  localparam int HDR_LEN    = 3;
  localparam int PAGE_LEN   = COLUMNS + HDR_LEN;

  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int PAGE_W = $clog2(PAGES);
  localparam int SLOT_W = $clog2(PAGE_LEN);

  // Panel command bytes sent ahead of each page
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LO_CMD    = 8'h00;
  localparam logic [7:0] COL_HI_CMD    = 8'h10;

  // Operation queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Input word commands
  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_EMIT  = 2'd2
  } cmd_t;

  // Classified work for the back end
  typedef enum logic [1:0] {
    OP_DRAW,
    OP_CLEAR,
    OP_EMIT_CMD,
    OP_EMIT_DATA
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic              pixel_on;
    logic [7:0]        cmd_byte;
    logic              last;
  } op_t;

endpackage

// ----- sv/page_framebuffer_engine_core.sv -----
// Top level of the page-organized monochrome frame store and transfer sequencer.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-----------------------------
//   in      | in_valid, in_ready, cmd, x_coord, y_coord, | draw / clear / emit word
//           | pixel_on                                  |
//   out     | out_valid, out_ready, out_byte, is_data,   | one transfer byte per emit
//           | frame_end                                 |
//
// A draw or a data emit reads the store in the back end, then writes the byte back or
// loads it into the output; a command emit loads its byte straight from the queue; a clear
// writes every store address through the single write port of the store. After reset a sweep
// zeroes the store while in_ready stays low. A four-deep queue lets the front keep
// accepting words while the back end stalls on a full output register or a sweep.
module page_framebuffer_engine_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] x_coord,
  input  logic [7:0] y_coord,
  input  logic       pixel_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       frame_end
);
  import pfe_pkg::*;

  logic init_busy;
  logic q_full;
  logic q_push;
  op_t  q_op;
  logic q_pop;
  logic q_valid;
  op_t  q_head;

  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .pixel_on  (pixel_on),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  pfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .frame_end (frame_end)
  );

endmodule

// ----- sv/pfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/pfe_front.sv -----
// Front end: accepts input words, drops no-ops, tracks the transfer position.
module pfe_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     cmd,
  input  logic [7:0]     x_coord,
  input  logic [7:0]     y_coord,
  input  logic           pixel_on,
  input  logic           init_busy,
  input  logic           q_full,
  output logic           q_push,
  output pfe_pkg::op_t   q_op
);
  import pfe_pkg::*;

  logic [PAGE_W-1:0] page;
  logic [SLOT_W-1:0] slot;
  logic              accept;
  logic              in_range;
  logic              last_byte;

  // Take a word when the store is live and the queue has room
  assign in_ready = !init_busy && !q_full;
  assign accept   = in_valid && in_ready;

  assign in_range  = (32'(x_coord) < COLUMNS) && (32'(y_coord) < ROWS);
  assign last_byte = (32'(page) == PAGES - 1) && (32'(slot) == PAGE_LEN - 1);

  // Classify the word into a back-end operation
  always_comb begin
    q_op          = '0;
    q_op.kind     = OP_DRAW;
    q_op.pixel_on = pixel_on;
    q_op.bit_sel  = y_coord[2:0];
    q_op.addr     = ADDR_W'(32'(y_coord >> 3) * COLUMNS + 32'(x_coord));
    q_op.last     = last_byte;
    q_push        = 1'b0;
    unique case (cmd)
      CMD_DRAW: begin
        q_push = accept && in_range;
      end
      CMD_CLEAR: begin
        q_op.kind = OP_CLEAR;
        q_push    = accept;
      end
      CMD_EMIT: begin
        q_push = accept;
        priority if (32'(slot) == 0) begin
          q_op.kind     = OP_EMIT_CMD;
          q_op.cmd_byte = PAGE_CMD_BASE + 8'(page);
        end else if (32'(slot) == 1) begin
          q_op.kind     = OP_EMIT_CMD;
          q_op.cmd_byte = COL_LO_CMD;
        end else if (32'(slot) == 2) begin
          q_op.kind     = OP_EMIT_CMD;
          q_op.cmd_byte = COL_HI_CMD;
        end else begin
          q_op.kind = OP_EMIT_DATA;
          q_op.addr = ADDR_W'(32'(page) * COLUMNS + 32'(slot) - HDR_LEN);
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Advance the transfer position on each emit word, wrapping after the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= '0;
      slot <= '0;
    end else if (accept && cmd == CMD_EMIT) begin
      if (32'(slot) == PAGE_LEN - 1) begin
        slot <= '0;
        page <= last_byte ? '0 : page + 1'b1;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

endmodule

// ----- sv/pfe_queue.sv -----
// Short operation queue that decouples the front end from the back end.
module pfe_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pfe_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output pfe_pkg::op_t head_op
);
  import pfe_pkg::*;

  op_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = (32'(count) == Q_DEPTH);
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      32'(count) <= Q_DEPTH)
    else $error("queue count out of range");

endmodule

// ----- sv/pfe_back.sv -----
// Back end: runs pixel read-modify-writes, clear sweeps, transfer reads and command byte loads.
module pfe_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  pfe_pkg::op_t q_head,
  output logic         q_pop,
  output logic         init_busy,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         is_data,
  output logic         frame_end
);
  import pfe_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAW,
    S_EMIT
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] sweep_addr;
  op_t               op_hold;
  logic              out_can_load;
  logic              out_load;
  logic              sweep_done;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        bit_mask;

  pfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_can_load = !out_valid || out_ready;
  assign sweep_done   = (32'(sweep_addr) == STORE_SIZE - 1);
  assign bit_mask     = 8'(1) << op_hold.bit_sel;

  // Drive the store ports, the queue pop and the output load
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = q_head.addr;
    wr_en    = 1'b0;
    wr_addr  = sweep_addr;
    wr_data  = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_head.kind)
            OP_EMIT_CMD: begin
              q_pop    = out_can_load;
              out_load = out_can_load;
            end
            OP_DRAW, OP_EMIT_DATA: begin
              q_pop = 1'b1;
              rd_en = 1'b1;
            end
            OP_CLEAR: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_DRAW: begin
        wr_en   = 1'b1;
        wr_addr = op_hold.addr;
        wr_data = op_hold.pixel_on ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
      end
      S_EMIT: begin
        out_load = out_can_load;
      end
    endcase
  end

  // Hold state and the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep_addr <= '0;
      init_busy  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      // Load a new word, or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (sweep_done) begin
            state      <= S_IDLE;
            sweep_addr <= '0;
            init_busy  <= 1'b0;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            op_hold <= q_head;
            unique case (q_head.kind)
              OP_EMIT_CMD: begin
                out_byte  <= q_head.cmd_byte;
                is_data   <= 1'b0;
                frame_end <= q_head.last;
              end
              OP_DRAW: begin
                state <= S_DRAW;
              end
              OP_EMIT_DATA: begin
                state <= S_EMIT;
              end
              OP_CLEAR: begin
                state <= S_CLEAR;
              end
            endcase
          end
        end
        S_DRAW: begin
          state <= S_IDLE;
        end
        S_EMIT: begin
          if (out_can_load) begin
            out_byte  <= rd_data;
            is_data   <= 1'b1;
            frame_end <= op_hold.last;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_pop_in_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |-> state == S_IDLE)
    else $error("operation popped outside idle");
  a_draw_one_cycle: assert property (@(posedge clk) disable iff (rst)
      state == S_DRAW |=> state == S_IDLE)
    else $error("pixel write did not complete in one cycle");
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
      wr_en |-> !rd_en)
    else $error("store read issued during a write");
  a_init_only_clear: assert property (@(posedge clk) disable iff (rst)
      init_busy |-> state == S_CLEAR && !q_pop)
    else $error("work started during the reset sweep");

endmodule
